### hw/rtl/pimrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pimrv_pkg
// Shared types, widths and ray constants for the point-in-mesh ray vote unit.
// ----------------------------------------------------------------------------
package pimrv_pkg;

  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int OPND_W   = DIFF_W + 1;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int XV_W     = 2 * DIFF_W + 1;
  localparam int SPLIT    = DIFF_W;
  localparam int TN_W     = DIFF_W + XV_W + 2;
  localparam int DIR_FRAC = 16;
  localparam int DIR_ONE  = 1 << DIR_FRAC;
  localparam int DIR_S1   = (DIR_ONE + 5000) / 10000;
  localparam int DIR_S2   = (2 * DIR_ONE + 5000) / 10000;
  localparam int DIR_S3   = (3 * DIR_ONE + 5000) / 10000;
  localparam int DOT_W    = XV_W + DIR_FRAC + 3;
  localparam int CMP_W    = TN_W + 2;
  localparam int STEP_W   = 5;
  localparam int NUM_XV   = 9;

  localparam logic [STEP_W-1:0] STEP_TN_FIRST = STEP_W'(18);
  localparam logic [STEP_W-1:0] STEP_TN_HIGH  = STEP_W'(21);
  localparam logic [STEP_W-1:0] STEP_LAST     = STEP_W'(23);

  localparam logic [1:0] REG_POINT_X = 2'd0;
  localparam logic [1:0] REG_POINT_Y = 2'd1;
  localparam logic [1:0] REG_POINT_Z = 2'd2;

  localparam logic [1:0] RAY_X = 2'd0;
  localparam logic [1:0] RAY_Y = 2'd1;
  localparam logic [1:0] RAY_Z = 2'd2;

  localparam int SLOT_Q = 0;
  localparam int SLOT_C = 3;
  localparam int SLOT_W = 6;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic                      last_triangle;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic parity_ray_x;
    logic parity_ray_y;
    logic parity_ray_z;
  } out_word_t;

  typedef struct packed {
    logic [NUM_XV-1:0][XV_W-1:0] xv;
    logic [TN_W-1:0]             tn;
    logic                        last;
  } job_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } fifo_stat_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_DOT, B_TEST} back_state_t;

  function automatic logic signed [DOT_W-1:0] dir_dot(
    input logic [1:0]             ray,
    input logic signed [XV_W-1:0] a0,
    input logic signed [XV_W-1:0] a1,
    input logic signed [XV_W-1:0] a2
  );
    logic signed [DOT_W-1:0] x0;
    logic signed [DOT_W-1:0] x1;
    logic signed [DOT_W-1:0] x2;
    logic signed [DOT_W-1:0] r;
    x0 = DOT_W'(a0);
    x1 = DOT_W'(a1);
    x2 = DOT_W'(a2);
    case (ray)
      RAY_X:   r = x0 * DIR_ONE + x1 * DIR_S1 + x2 * DIR_S2;
      RAY_Y:   r = x0 * DIR_S3 + x1 * DIR_ONE + x2 * DIR_S1;
      RAY_Z:   r = x0 * DIR_S2 + x1 * DIR_S3 + x2 * DIR_ONE;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/point_in_mesh_ray_vote_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_mesh_ray_vote_unit
// Point-in-mesh test by crossing parity along three skewed rays with a
// two-of-three vote, reported on the triangle marked last.
//
//   channel  ports                         word
//   input    in_push / in_full / in_data   one triangle, in_word_t
//   result   out_pop / out_empty / out_data  vote and parities, out_word_t
//   config   cfg_we / cfg_index / cfg_wdata  query point x, y, z
//
// A triangle holds the front through accept, 24 products on the one shared
// 26x26 multiplier and hand-off to the job queue. The back takes a job, then
// runs a dot and a test state per ray, so the front multiplier sets the rate.
// Reset clears state, parities and the queue; the point registers read zero.
// A waiting result stalls only a last-triangle job; the queue absorbs the rest.
// ----------------------------------------------------------------------------
module point_in_mesh_ray_vote_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  pimrv_pkg::in_word_t           in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output pimrv_pkg::out_word_t          out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pimrv_pkg::COORD_W-1:0] cfg_wdata
);
  import pimrv_pkg::*;

  logic       job_push, job_pop;
  job_t       job_wdata, job_rdata;
  fifo_stat_t job_stat;

  pimrv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .job_push  (job_push),
    .job_full  (job_stat.full),
    .job_data  (job_wdata)
  );

  pimrv_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .pop   (job_pop),
    .rdata (job_rdata),
    .stat  (job_stat)
  );

  pimrv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_stat.empty),
    .job_pop   (job_pop),
    .job_data  (job_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full |=> in_full)
    else $error("front took a word without going busy");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (job_stat.count == 2'd2) == job_stat.full && !(job_push && job_stat.full))
    else $error("job queue count and full flag disagree");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("reset left a result or a busy front");

endmodule

### hw/rtl/pimrv_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pimrv_front
// Accepts a triangle, forms its edges and the offset to the query point, and
// builds the ray-independent cross products and triple product on one shared
// multiplier, one product a cycle.
// ----------------------------------------------------------------------------
module pimrv_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  pimrv_pkg::in_word_t      in_data,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [pimrv_pkg::COORD_W-1:0] cfg_wdata,
  output logic                     job_push,
  input  logic                     job_full,
  output pimrv_pkg::job_t          job_data
);
  import pimrv_pkg::*;

  front_state_t               state_r, state_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic signed [COORD_W-1:0]  pt_r [3];
  logic signed [DIFF_W-1:0]   e1_r [3], e1_nxt [3];
  logic signed [DIFF_W-1:0]   e2_r [3], e2_nxt [3];
  logic signed [DIFF_W-1:0]   t_r [3], t_nxt [3];
  logic signed [XV_W-1:0]     part_r, part_nxt;
  logic signed [XV_W-1:0]     xv_r [NUM_XV], xv_nxt [NUM_XV];
  logic signed [TN_W-1:0]     tn_r, tn_nxt;
  logic                       last_r, last_nxt;
  logic signed [OPND_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [TN_W-1:0]     tn_term;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      5'd0:  begin mul_a = OPND_W'(t_r[1]);  mul_b = OPND_W'(e1_r[2]); end
      5'd1:  begin mul_a = OPND_W'(t_r[2]);  mul_b = OPND_W'(e1_r[1]); end
      5'd2:  begin mul_a = OPND_W'(t_r[2]);  mul_b = OPND_W'(e1_r[0]); end
      5'd3:  begin mul_a = OPND_W'(t_r[0]);  mul_b = OPND_W'(e1_r[2]); end
      5'd4:  begin mul_a = OPND_W'(t_r[0]);  mul_b = OPND_W'(e1_r[1]); end
      5'd5:  begin mul_a = OPND_W'(t_r[1]);  mul_b = OPND_W'(e1_r[0]); end
      5'd6:  begin mul_a = OPND_W'(e2_r[1]); mul_b = OPND_W'(e1_r[2]); end
      5'd7:  begin mul_a = OPND_W'(e2_r[2]); mul_b = OPND_W'(e1_r[1]); end
      5'd8:  begin mul_a = OPND_W'(e2_r[2]); mul_b = OPND_W'(e1_r[0]); end
      5'd9:  begin mul_a = OPND_W'(e2_r[0]); mul_b = OPND_W'(e1_r[2]); end
      5'd10: begin mul_a = OPND_W'(e2_r[0]); mul_b = OPND_W'(e1_r[1]); end
      5'd11: begin mul_a = OPND_W'(e2_r[1]); mul_b = OPND_W'(e1_r[0]); end
      5'd12: begin mul_a = OPND_W'(e2_r[1]); mul_b = OPND_W'(t_r[2]);  end
      5'd13: begin mul_a = OPND_W'(e2_r[2]); mul_b = OPND_W'(t_r[1]);  end
      5'd14: begin mul_a = OPND_W'(e2_r[2]); mul_b = OPND_W'(t_r[0]);  end
      5'd15: begin mul_a = OPND_W'(e2_r[0]); mul_b = OPND_W'(t_r[2]);  end
      5'd16: begin mul_a = OPND_W'(e2_r[0]); mul_b = OPND_W'(t_r[1]);  end
      5'd17: begin mul_a = OPND_W'(e2_r[1]); mul_b = OPND_W'(t_r[0]);  end
      5'd18: begin
        mul_a = OPND_W'(e2_r[0]);
        mul_b = $signed({1'b0, xv_r[SLOT_Q][SPLIT-1:0]});
      end
      5'd19: begin
        mul_a = OPND_W'(e2_r[1]);
        mul_b = $signed({1'b0, xv_r[SLOT_Q+1][SPLIT-1:0]});
      end
      5'd20: begin
        mul_a = OPND_W'(e2_r[2]);
        mul_b = $signed({1'b0, xv_r[SLOT_Q+2][SPLIT-1:0]});
      end
      5'd21: begin
        mul_a = OPND_W'(e2_r[0]);
        mul_b = $signed(xv_r[SLOT_Q][XV_W-1:SPLIT]);
      end
      5'd22: begin
        mul_a = OPND_W'(e2_r[1]);
        mul_b = $signed(xv_r[SLOT_Q+1][XV_W-1:SPLIT]);
      end
      5'd23: begin
        mul_a = OPND_W'(e2_r[2]);
        mul_b = $signed(xv_r[SLOT_Q+2][XV_W-1:SPLIT]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign tn_term = (step_r >= STEP_TN_HIGH) ? (TN_W'(prod) <<< SPLIT) : TN_W'(prod);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    t_nxt     = t_r;
    part_nxt  = part_r;
    xv_nxt    = xv_r;
    tn_nxt    = tn_r;
    last_nxt  = last_r;
    job_push  = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (in_push) begin
          e1_nxt[0] = DIFF_W'(in_data.v1_x) - DIFF_W'(in_data.v0_x);
          e1_nxt[1] = DIFF_W'(in_data.v1_y) - DIFF_W'(in_data.v0_y);
          e1_nxt[2] = DIFF_W'(in_data.v1_z) - DIFF_W'(in_data.v0_z);
          e2_nxt[0] = DIFF_W'(in_data.v2_x) - DIFF_W'(in_data.v0_x);
          e2_nxt[1] = DIFF_W'(in_data.v2_y) - DIFF_W'(in_data.v0_y);
          e2_nxt[2] = DIFF_W'(in_data.v2_z) - DIFF_W'(in_data.v0_z);
          t_nxt[0]  = DIFF_W'(pt_r[0]) - DIFF_W'(in_data.v0_x);
          t_nxt[1]  = DIFF_W'(pt_r[1]) - DIFF_W'(in_data.v0_y);
          t_nxt[2]  = DIFF_W'(pt_r[2]) - DIFF_W'(in_data.v0_z);
          last_nxt  = in_data.last_triangle;
          step_nxt  = '0;
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        if (step_r < STEP_TN_FIRST) begin
          if (!step_r[0]) begin
            part_nxt = prod[XV_W-1:0];
          end else begin
            xv_nxt[step_r[STEP_W-1:1]] = part_r - prod[XV_W-1:0];
          end
        end else if (step_r == STEP_TN_FIRST) begin
          tn_nxt = tn_term;
        end else begin
          tn_nxt = tn_r + tn_term;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!job_full) begin
          job_push  = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
      pt_r[0] <= '0;
      pt_r[1] <= '0;
      pt_r[2] <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_X: pt_r[0] <= $signed(cfg_wdata);
          REG_POINT_Y: pt_r[1] <= $signed(cfg_wdata);
          REG_POINT_Z: pt_r[2] <= $signed(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    e1_r   <= e1_nxt;
    e2_r   <= e2_nxt;
    t_r    <= t_nxt;
    part_r <= part_nxt;
    xv_r   <= xv_nxt;
    tn_r   <= tn_nxt;
    last_r <= last_nxt;
  end

  assign in_full = (state_r != F_IDLE);

  always_comb begin
    for (int i = 0; i < NUM_XV; i++) begin
      job_data.xv[i] = xv_r[i];
    end
    job_data.tn   = tn_r;
    job_data.last = last_r;
  end

endmodule

### hw/rtl/pimrv_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pimrv_fifo
// Two-entry queue of triangle jobs between the front and back parts.
// ----------------------------------------------------------------------------
module pimrv_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pimrv_pkg::job_t       wdata,
  input  logic                  pop,
  output pimrv_pkg::job_t       rdata,
  output pimrv_pkg::fifo_stat_t stat
);
  import pimrv_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

endmodule

### hw/rtl/pimrv_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pimrv_back
// Runs the hit test for the three rays of a job, a dot and a test state per
// ray, keeps the crossing parities and posts the vote on the last triangle.
// ----------------------------------------------------------------------------
module pimrv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_empty,
  output logic                 job_pop,
  input  pimrv_pkg::job_t      job_data,
  output logic                 out_empty,
  input  logic                 out_pop,
  output pimrv_pkg::out_word_t out_data
);
  import pimrv_pkg::*;

  back_state_t             state_r, state_nxt;
  logic [1:0]              ray_r, ray_nxt;
  job_t                    job_r, job_nxt;
  logic signed [DOT_W-1:0] det_r, det_nxt;
  logic signed [DOT_W-1:0] un_r, un_nxt;
  logic signed [DOT_W-1:0] vn_r, vn_nxt;
  logic [2:0]              par_r, par_nxt;
  logic                    ov_r, ov_nxt;
  out_word_t               od_r, od_nxt;
  logic signed [CMP_W-1:0] nd, nu, nv, nt, r1, r2;
  logic                    neg, hit, slot_free;
  logic [2:0]              par_hit;

  always_comb begin
    neg = det_r[DOT_W-1];
    nd  = neg ? -CMP_W'(det_r) : CMP_W'(det_r);
    nu  = neg ? -CMP_W'(un_r) : CMP_W'(un_r);
    nv  = neg ? -CMP_W'(vn_r) : CMP_W'(vn_r);
    nt  = neg ? -CMP_W'($signed(job_r.tn)) : CMP_W'($signed(job_r.tn));
    r1  = nd - nu;
    r2  = r1 - nv;
    hit = (det_r != '0) && !nu[CMP_W-1] && !r1[CMP_W-1] && !nv[CMP_W-1]
          && !r2[CMP_W-1] && !nt[CMP_W-1] && (nt != '0);
    par_hit = hit ? (par_r ^ (3'b001 << ray_r)) : par_r;
  end

  assign slot_free = !ov_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    ray_nxt   = ray_r;
    job_nxt   = job_r;
    det_nxt   = det_r;
    un_nxt    = un_r;
    vn_nxt    = vn_r;
    par_nxt   = par_r;
    ov_nxt    = (ov_r && out_pop) ? 1'b0 : ov_r;
    od_nxt    = od_r;
    job_pop   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          job_nxt   = job_data;
          ray_nxt   = RAY_X;
          state_nxt = B_DOT;
        end
      end
      B_DOT: begin
        det_nxt = dir_dot(ray_r, $signed(job_r.xv[SLOT_C]), $signed(job_r.xv[SLOT_C+1]),
                          $signed(job_r.xv[SLOT_C+2]));
        un_nxt  = dir_dot(ray_r, $signed(job_r.xv[SLOT_W]), $signed(job_r.xv[SLOT_W+1]),
                          $signed(job_r.xv[SLOT_W+2]));
        vn_nxt  = dir_dot(ray_r, $signed(job_r.xv[SLOT_Q]), $signed(job_r.xv[SLOT_Q+1]),
                          $signed(job_r.xv[SLOT_Q+2]));
        state_nxt = B_TEST;
      end
      B_TEST: begin
        if (ray_r != RAY_Z) begin
          par_nxt   = par_hit;
          ray_nxt   = ray_r + 2'd1;
          state_nxt = B_DOT;
        end else if (!job_r.last) begin
          par_nxt   = par_hit;
          state_nxt = B_IDLE;
        end else if (slot_free) begin
          od_nxt.inside_res   = (par_hit[0] & par_hit[1]) | (par_hit[0] & par_hit[2])
                                | (par_hit[1] & par_hit[2]);
          od_nxt.parity_ray_x = par_hit[0];
          od_nxt.parity_ray_y = par_hit[1];
          od_nxt.parity_ray_z = par_hit[2];
          ov_nxt    = 1'b1;
          par_nxt   = '0;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ray_r   <= RAY_X;
      par_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ray_r   <= ray_nxt;
      par_r   <= par_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    det_r <= det_nxt;
    un_r  <= un_nxt;
    vn_r  <= vn_nxt;
    od_r  <= od_nxt;
  end

  assign out_empty = !ov_r;
  assign out_data  = od_r;

endmodule
